// ===== design/rpv_pkg.sv =====
`timescale 1ns / 1ps

package rpv_pkg;

    // Fixed field widths
    localparam int COORD_W    = 20;
    localparam int REL_W      = COORD_W + 1;
    localparam int FRAC_BITS  = 16;
    localparam int S_W        = 42;
    localparam int LIMIT_W    = 22;
    localparam int MINPTS_W   = 24;
    localparam int GAIN_W     = 19;
    localparam int KEPT_OUT_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Defaults for the top-level parameters
    localparam int ACCUM_BITS_DEF = 48;
    localparam int COUNT_BITS_DEF = 24;

    // Shared divide / square-root unit
    localparam int ITER_W   = 64;
    localparam int REM_W    = ITER_W + 2;
    localparam int STEP_W   = 7;

    // Queue between front and back
    localparam int QDEPTH = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PTS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_Z = 3'd7;

    // Reset values of the configuration registers
    localparam logic signed [COORD_W-1:0] RST_ROBOT_X   = 20'sd3932;
    localparam logic signed [COORD_W-1:0] RST_ROBOT_Y   = 20'sd0;
    localparam logic signed [COORD_W-1:0] RST_ROBOT_Z   = 20'sd0;
    localparam logic [LIMIT_W-1:0]        RST_NEAR      = 22'd164;
    localparam logic [LIMIT_W-1:0]        RST_FAR       = 22'd7864;
    localparam logic [MINPTS_W-1:0]       RST_MIN_PTS   = 24'd20;
    localparam logic [GAIN_W-1:0]         RST_GAIN      = 19'd6554;
    localparam logic signed [COORD_W-1:0] RST_FORWARD_Z = -20'sd13107;

    // One classified point as it waits in the queue
    typedef struct packed {
        logic signed [REL_W-1:0] rel_x;
        logic signed [REL_W-1:0] rel_y;
        logic signed [REL_W-1:0] rel_z;
        logic                    skip;
        logic                    last;
    } point_entry_t;

    // Settings the back end needs
    typedef struct packed {
        logic [LIMIT_W-1:0]        near_sq;
        logic [LIMIT_W-1:0]        far_sq;
        logic [MINPTS_W-1:0]       min_points;
        logic [GAIN_W-1:0]         gain;
        logic signed [COORD_W-1:0] forward_z;
    } back_cfg_t;

    // Request to the divide / square-root unit
    typedef struct packed {
        logic              start;
        logic              sqrt_mode;
        logic [STEP_W-1:0] steps;
        logic [REM_W-1:0]  rem_init;
        logic [ITER_W-1:0] dsh_init;
        logic [ITER_W-1:0] divisor;
    } iter_req_t;

    // Status of the divide / square-root unit
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [ITER_W-1:0] result;
    } iter_rsp_t;

    // Magnitude of a signed offset; the most negative value maps to 2^20.
    function automatic logic [REL_W-1:0] rel_mag(input logic signed [REL_W-1:0] v);
        logic [REL_W-1:0] r;
        r = v[REL_W-1] ? REL_W'(-v) : REL_W'(v);
        return r;
    endfunction

endpackage

// ===== design/rpv_stream_if.sv =====
`timescale 1ns / 1ps

// Point channel
interface rpv_point_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rpv_pkg::COORD_W-1:0]   point_x;
    logic signed [rpv_pkg::COORD_W-1:0]   point_y;
    logic signed [rpv_pkg::COORD_W-1:0]   point_z;
    logic                                 point_invalid;
    logic                                 last_point;

    modport source (output valid, point_x, point_y, point_z, point_invalid, last_point,
                    input ready);
    modport sink (input valid, point_x, point_y, point_z, point_invalid, last_point,
                  output ready);
endinterface

// Goal channel
interface rpv_goal_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [rpv_pkg::COORD_W-1:0]    goal_x;
    logic signed [rpv_pkg::COORD_W-1:0]    goal_y;
    logic signed [rpv_pkg::COORD_W-1:0]    goal_z;
    logic [rpv_pkg::KEPT_OUT_W-1:0]        kept_points;
    logic                                  repulsion_applied;

    modport source (output valid, goal_x, goal_y, goal_z, kept_points, repulsion_applied,
                    input ready);
    modport sink (input valid, goal_x, goal_y, goal_z, kept_points, repulsion_applied,
                  output ready);
endinterface

// ===== design/rpv_front.sv =====
`timescale 1ns / 1ps

module rpv_front (
    rpv_point_if.sink                        point,
    input  logic signed [rpv_pkg::COORD_W-1:0] robot_x,
    input  logic signed [rpv_pkg::COORD_W-1:0] robot_y,
    input  logic signed [rpv_pkg::COORD_W-1:0] robot_z,
    input  logic                             q_full,
    output logic                             q_push,
    output rpv_pkg::point_entry_t            q_entry
);

    // A transfer happens whenever a point is valid and the queue has room.
    assign point.ready = !q_full;
    assign q_push      = point.valid && !q_full;

    // Offset from the robot, one bit wider than the coordinates.
    always_comb
    begin
        q_entry.rel_x = rpv_pkg::REL_W'(point.point_x) - rpv_pkg::REL_W'(robot_x);
        q_entry.rel_y = rpv_pkg::REL_W'(point.point_y) - rpv_pkg::REL_W'(robot_y);
        q_entry.rel_z = rpv_pkg::REL_W'(point.point_z) - rpv_pkg::REL_W'(robot_z);
        q_entry.skip  = point.point_invalid;
        q_entry.last  = point.last_point;
    end

endmodule

// ===== design/rpv_queue.sv =====
`timescale 1ns / 1ps

module rpv_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rpv_pkg::point_entry_t push_data,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output rpv_pkg::point_entry_t pop_data
);

    localparam int AW = (rpv_pkg::QDEPTH > 1) ? $clog2(rpv_pkg::QDEPTH) : 1;
    localparam int CW = $clog2(rpv_pkg::QDEPTH + 1);

    rpv_pkg::point_entry_t entry_reg [rpv_pkg::QDEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] fill_reg;

    assign full      = (fill_reg == CW'(rpv_pkg::QDEPTH));
    assign not_empty = (fill_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(rpv_pkg::QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(rpv_pkg::QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/rpv_iter.sv =====
`timescale 1ns / 1ps

module rpv_iter (
    input  logic               clk,
    input  logic               rst_n,
    input  rpv_pkg::iter_req_t req,
    output rpv_pkg::iter_rsp_t rsp
);

    logic                           busy_reg;
    logic                           done_reg;
    logic                           sqrt_reg;
    logic [rpv_pkg::STEP_W-1:0]     cnt_reg;
    logic [rpv_pkg::REM_W-1:0]      rem_reg;
    logic [rpv_pkg::ITER_W-1:0]     dsh_reg;
    logic [rpv_pkg::ITER_W-1:0]     div_reg;
    logic [rpv_pkg::ITER_W-1:0]     res_reg;

    logic [rpv_pkg::REM_W-1:0]      trial_rem;
    logic [rpv_pkg::REM_W-1:0]      trial_sub;
    logic                           fits;

    // One quotient bit or one root bit per cycle.
    always_comb
    begin
        if (sqrt_reg)
        begin
            trial_rem = {rem_reg[rpv_pkg::REM_W-3:0], dsh_reg[rpv_pkg::ITER_W-1 -: 2]};
            trial_sub = {res_reg, 2'b01};
        end
        else
        begin
            trial_rem = {rem_reg[rpv_pkg::REM_W-2:0], dsh_reg[rpv_pkg::ITER_W-1]};
            trial_sub = {2'b00, div_reg};
        end
        fits = (trial_rem >= trial_sub);
    end

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sqrt_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dsh_reg  <= '0;
            div_reg  <= '0;
            res_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                sqrt_reg <= req.sqrt_mode;
                cnt_reg  <= req.steps;
                rem_reg  <= req.rem_init;
                dsh_reg  <= req.dsh_init;
                div_reg  <= req.divisor;
                res_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? trial_rem - trial_sub : trial_rem;
                res_reg <= {res_reg[rpv_pkg::ITER_W-2:0], fits};
                dsh_reg <= sqrt_reg ? {dsh_reg[rpv_pkg::ITER_W-3:0], 2'b00}
                                    : {dsh_reg[rpv_pkg::ITER_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == rpv_pkg::STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== design/rpv_back.sv =====
`timescale 1ns / 1ps

module rpv_back #(
    parameter int ACCUM_BITS = rpv_pkg::ACCUM_BITS_DEF,
    parameter int COUNT_BITS = rpv_pkg::COUNT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_not_empty,
    input  rpv_pkg::point_entry_t q_data,
    output logic                  q_pop,
    input  rpv_pkg::back_cfg_t    cfg,
    output rpv_pkg::iter_req_t    iter_req,
    input  rpv_pkg::iter_rsp_t    iter_rsp,
    rpv_goal_if.source            goal
);

    localparam int EXT_W = 66;
    localparam logic signed [EXT_W-1:0] ACC_MAX = (EXT_W'(1) <<< (ACCUM_BITS - 1)) - EXT_W'(1);
    localparam logic signed [EXT_W-1:0] ACC_MIN = -ACC_MAX - EXT_W'(1);
    localparam logic [rpv_pkg::KEPT_OUT_W-1:0] KEPT_SAT = '1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQ_X, ST_SQ_Y, ST_SQ_Z, ST_SQ_SUM, ST_WINDOW, ST_ROOT, ST_WDIV,
        ST_AXIS, ST_UDIV, ST_MUL_LO, ST_MUL_HI, ST_ACCUM,
        ST_G_CHECK, ST_G_NORM, ST_G_SQ0, ST_G_SQ1, ST_G_SQ2, ST_G_SQSUM, ST_G_ROOT,
        ST_G_MUL, ST_G_DIV_START, ST_G_DIV, ST_G_OUT
    } state_t;

    state_t                          state_reg;
    rpv_pkg::point_entry_t           entry_reg;
    logic [rpv_pkg::S_W-1:0]         s_reg;
    logic [28:0]                     d_reg;
    logic [40:0]                     w_reg;
    logic [30:0]                     u_reg;
    logic [63:0]                     lo_reg;
    logic [63:0]                     mul_p_reg;
    logic [1:0]                      axis_reg;
    logic signed [ACCUM_BITS-1:0]    sum_reg [3];
    logic [COUNT_BITS-1:0]           count_reg;
    logic                            applied_reg;
    logic [ACCUM_BITS-1:0]           m_reg [3];
    logic [ACCUM_BITS-1:0]           mx_reg;
    logic [63:0]                     q_reg;
    logic [31:0]                     mg_reg;
    logic signed [rpv_pkg::COORD_W-1:0] goal_reg [3];
    rpv_pkg::iter_req_t              req_reg;

    logic                            out_valid_reg;
    logic signed [rpv_pkg::COORD_W-1:0] out_x_reg;
    logic signed [rpv_pkg::COORD_W-1:0] out_y_reg;
    logic signed [rpv_pkg::COORD_W-1:0] out_z_reg;
    logic [rpv_pkg::KEPT_OUT_W-1:0]  out_kept_reg;
    logic                            out_applied_reg;

    logic [31:0]                     mul_a;
    logic [31:0]                     mul_b;
    logic signed [rpv_pkg::REL_W-1:0] rel_cur;
    logic [rpv_pkg::REL_W-1:0]       mag_cur;
    logic [42:0]                     term;
    logic signed [EXT_W-1:0]         acc_wide;
    logic signed [ACCUM_BITS-1:0]    acc_sat;
    logic [ACCUM_BITS-1:0]           sum_mag [3];
    logic [ACCUM_BITS-1:0]           mag_max;
    logic                            any_sum;
    logic                            kept_win;
    logic [63:0]                     q_sum;
    logic [63:0]                     gdiv_num;
    logic signed [21:0]              comp_c;
    logic signed [21:0]              comp_val;
    logic signed [rpv_pkg::COORD_W-1:0] comp_sat;
    logic [rpv_pkg::KEPT_OUT_W-1:0]  kept_out;
    logic                            count_gt;

    assign iter_req = req_reg;
    assign q_pop    = (state_reg == ST_IDLE) && q_not_empty;

    assign goal.valid             = out_valid_reg;
    assign goal.goal_x            = out_x_reg;
    assign goal.goal_y            = out_y_reg;
    assign goal.goal_z            = out_z_reg;
    assign goal.kept_points       = out_kept_reg;
    assign goal.repulsion_applied = out_applied_reg;

    // Offset of the axis in work and its magnitude
    always_comb
    begin
        case (axis_reg)
            2'd0:    rel_cur = entry_reg.rel_x;
            2'd1:    rel_cur = entry_reg.rel_y;
            default: rel_cur = entry_reg.rel_z;
        endcase
        mag_cur = rpv_pkg::rel_mag(rel_cur);
    end

    // Operands of the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQ_X:
            begin
                mul_a = 32'(rpv_pkg::rel_mag(entry_reg.rel_x));
                mul_b = mul_a;
            end
            ST_SQ_Y:
            begin
                mul_a = 32'(rpv_pkg::rel_mag(entry_reg.rel_y));
                mul_b = mul_a;
            end
            ST_SQ_Z:
            begin
                mul_a = 32'(rpv_pkg::rel_mag(entry_reg.rel_z));
                mul_b = mul_a;
            end
            ST_MUL_LO:
            begin
                mul_a = 32'(u_reg);
                mul_b = w_reg[31:0];
            end
            ST_MUL_HI:
            begin
                mul_a = 32'(u_reg);
                mul_b = 32'(w_reg[40:32]);
            end
            ST_G_SQ0:
            begin
                mul_a = 32'(m_reg[0][29:0]);
                mul_b = mul_a;
            end
            ST_G_SQ1:
            begin
                mul_a = 32'(m_reg[1][29:0]);
                mul_b = mul_a;
            end
            ST_G_SQ2:
            begin
                mul_a = 32'(m_reg[2][29:0]);
                mul_b = mul_a;
            end
            ST_G_MUL:
            begin
                mul_a = 32'(cfg.gain);
                mul_b = 32'(m_reg[axis_reg][29:0]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Repulsion term floor(u*w / 2^30) and the saturating accumulate
    always_comb
    begin
        term     = 43'({mul_p_reg[39:0], 2'b00}) + 43'(lo_reg[63:30]);
        acc_wide = (rel_cur > 0) ? EXT_W'(sum_reg[axis_reg]) - EXT_W'(term)
                                 : EXT_W'(sum_reg[axis_reg]) + EXT_W'(term);
        if (acc_wide > ACC_MAX)
        begin
            acc_sat = ACCUM_BITS'(ACC_MAX);
        end
        else if (acc_wide < ACC_MIN)
        begin
            acc_sat = ACCUM_BITS'(ACC_MIN);
        end
        else
        begin
            acc_sat = ACCUM_BITS'(acc_wide);
        end
    end

    // Magnitudes of the sums and the largest one
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum_mag[i] = sum_reg[i][ACCUM_BITS-1] ? ACCUM_BITS'(-sum_reg[i])
                                                  : ACCUM_BITS'(sum_reg[i]);
        end
        mag_max = sum_mag[0];
        if (sum_mag[1] > mag_max)
        begin
            mag_max = sum_mag[1];
        end
        if (sum_mag[2] > mag_max)
        begin
            mag_max = sum_mag[2];
        end
        any_sum  = (sum_reg[0] != '0) || (sum_reg[1] != '0) || (sum_reg[2] != '0);
        count_gt = (33'(count_reg) > 33'(cfg.min_points));
        kept_out = (33'(count_reg) > 33'(KEPT_SAT)) ? KEPT_SAT
                                                    : rpv_pkg::KEPT_OUT_W'(count_reg);
    end

    // Distance window, with the limits scaled to the units of s
    assign kept_win = !((s_reg < rpv_pkg::S_W'({cfg.near_sq, 16'b0})) ||
                        (s_reg > rpv_pkg::S_W'({cfg.far_sq, 16'b0})));

    assign q_sum    = q_reg + mul_p_reg;
    assign gdiv_num = {mul_p_reg[62:0], 1'b0} + 64'(mg_reg);

    // Goal component: rounded quotient, signed as its sum, plus the forward term on z
    always_comb
    begin
        comp_c   = 22'(iter_rsp.result[20:0]);
        comp_val = sum_reg[axis_reg][ACCUM_BITS-1] ? -comp_c : comp_c;
        if (axis_reg == 2'd2)
        begin
            comp_val = comp_val + 22'(cfg.forward_z);
        end
        if (comp_val > 22'sd524287)
        begin
            comp_sat = 20'sd524287;
        end
        else if (comp_val < -22'sd524288)
        begin
            comp_sat = -20'sd524288;
        end
        else
        begin
            comp_sat = rpv_pkg::COORD_W'(comp_val);
        end
    end

    // Sequencer, shared multiplier and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_reg       <= '0;
            s_reg           <= '0;
            d_reg           <= '0;
            w_reg           <= '0;
            u_reg           <= '0;
            lo_reg          <= '0;
            mul_p_reg       <= '0;
            axis_reg        <= '0;
            count_reg       <= '0;
            applied_reg     <= 1'b0;
            mx_reg          <= '0;
            q_reg           <= '0;
            mg_reg          <= '0;
            req_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_x_reg       <= '0;
            out_y_reg       <= '0;
            out_z_reg       <= '0;
            out_kept_reg    <= '0;
            out_applied_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i]  <= '0;
                m_reg[i]    <= '0;
                goal_reg[i] <= '0;
            end
        end
        else
        begin
            mul_p_reg     <= 64'(mul_a) * 64'(mul_b);
            req_reg.start <= 1'b0;
            if (goal.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (q_not_empty)
                    begin
                        entry_reg <= q_data;
                        if (q_data.skip)
                        begin
                            state_reg <= q_data.last ? ST_G_CHECK : ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_SQ_X;
                        end
                    end
                end

                ST_SQ_X:
                begin
                    state_reg <= ST_SQ_Y;
                end

                ST_SQ_Y:
                begin
                    s_reg     <= rpv_pkg::S_W'(mul_p_reg);
                    state_reg <= ST_SQ_Z;
                end

                ST_SQ_Z:
                begin
                    s_reg     <= s_reg + rpv_pkg::S_W'(mul_p_reg);
                    state_reg <= ST_SQ_SUM;
                end

                ST_SQ_SUM:
                begin
                    s_reg     <= s_reg + rpv_pkg::S_W'(mul_p_reg);
                    state_reg <= ST_WINDOW;
                end

                ST_WINDOW:
                begin
                    if (!kept_win)
                    begin
                        state_reg <= entry_reg.last ? ST_G_CHECK : ST_IDLE;
                    end
                    else
                    begin
                        if (count_reg != '1)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        if (s_reg == '0)
                        begin
                            state_reg <= entry_reg.last ? ST_G_CHECK : ST_IDLE;
                        end
                        else
                        begin
                            // Distance: floor(sqrt(s * 2^16)) in 29 root steps
                            req_reg.start     <= 1'b1;
                            req_reg.sqrt_mode <= 1'b1;
                            req_reg.steps     <= rpv_pkg::STEP_W'(29);
                            req_reg.rem_init  <= '0;
                            req_reg.dsh_init  <= {s_reg, 22'b0};
                            req_reg.divisor   <= '0;
                            state_reg         <= ST_ROOT;
                        end
                    end
                end

                ST_ROOT:
                begin
                    if (iter_rsp.done)
                    begin
                        d_reg <= iter_rsp.result[28:0];
                        // Weight: 2^40 / s
                        req_reg.start     <= 1'b1;
                        req_reg.sqrt_mode <= 1'b0;
                        req_reg.steps     <= rpv_pkg::STEP_W'(41);
                        req_reg.rem_init  <= '0;
                        req_reg.dsh_init  <= {1'b1, 63'b0};
                        req_reg.divisor   <= 64'(s_reg);
                        state_reg         <= ST_WDIV;
                    end
                end

                ST_WDIV:
                begin
                    if (iter_rsp.done)
                    begin
                        w_reg     <= iter_rsp.result[40:0];
                        axis_reg  <= 2'd0;
                        state_reg <= ST_AXIS;
                    end
                end

                ST_AXIS:
                begin
                    if (mag_cur == '0)
                    begin
                        if (axis_reg == 2'd2)
                        begin
                            state_reg <= entry_reg.last ? ST_G_CHECK : ST_IDLE;
                        end
                        else
                        begin
                            axis_reg <= axis_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        // Unit component: |rel| * 2^38 / d
                        req_reg.start     <= 1'b1;
                        req_reg.sqrt_mode <= 1'b0;
                        req_reg.steps     <= rpv_pkg::STEP_W'(31);
                        req_reg.rem_init  <= rpv_pkg::REM_W'({mag_cur, 7'b0});
                        req_reg.dsh_init  <= '0;
                        req_reg.divisor   <= 64'(d_reg);
                        state_reg         <= ST_UDIV;
                    end
                end

                ST_UDIV:
                begin
                    if (iter_rsp.done)
                    begin
                        u_reg     <= iter_rsp.result[30:0];
                        state_reg <= ST_MUL_LO;
                    end
                end

                ST_MUL_LO:
                begin
                    state_reg <= ST_MUL_HI;
                end

                ST_MUL_HI:
                begin
                    lo_reg    <= mul_p_reg;
                    state_reg <= ST_ACCUM;
                end

                ST_ACCUM:
                begin
                    sum_reg[axis_reg] <= acc_sat;
                    if (axis_reg == 2'd2)
                    begin
                        state_reg <= entry_reg.last ? ST_G_CHECK : ST_IDLE;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 1'b1;
                        state_reg <= ST_AXIS;
                    end
                end

                ST_G_CHECK:
                begin
                    applied_reg <= count_gt && any_sum;
                    for (int i = 0; i < 3; i++)
                    begin
                        m_reg[i] <= sum_mag[i];
                    end
                    mx_reg    <= mag_max;
                    state_reg <= (count_gt && any_sum) ? ST_G_NORM : ST_G_OUT;
                end

                ST_G_NORM:
                begin
                    // Bring the largest magnitude into [2^29, 2^30), one bit a cycle
                    if (mx_reg[ACCUM_BITS-1:30] != '0)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            m_reg[i] <= m_reg[i] >> 1;
                        end
                        mx_reg <= mx_reg >> 1;
                    end
                    else if (!mx_reg[29])
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            m_reg[i] <= m_reg[i] << 1;
                        end
                        mx_reg <= mx_reg << 1;
                    end
                    else
                    begin
                        state_reg <= ST_G_SQ0;
                    end
                end

                ST_G_SQ0:
                begin
                    state_reg <= ST_G_SQ1;
                end

                ST_G_SQ1:
                begin
                    q_reg     <= mul_p_reg;
                    state_reg <= ST_G_SQ2;
                end

                ST_G_SQ2:
                begin
                    q_reg     <= q_sum;
                    state_reg <= ST_G_SQSUM;
                end

                ST_G_SQSUM:
                begin
                    q_reg             <= q_sum;
                    req_reg.start     <= 1'b1;
                    req_reg.sqrt_mode <= 1'b1;
                    req_reg.steps     <= rpv_pkg::STEP_W'(31);
                    req_reg.rem_init  <= '0;
                    req_reg.dsh_init  <= {q_sum[61:0], 2'b00};
                    req_reg.divisor   <= '0;
                    state_reg         <= ST_G_ROOT;
                end

                ST_G_ROOT:
                begin
                    if (iter_rsp.done)
                    begin
                        mg_reg    <= iter_rsp.result[31:0];
                        axis_reg  <= 2'd0;
                        state_reg <= ST_G_MUL;
                    end
                end

                ST_G_MUL:
                begin
                    state_reg <= ST_G_DIV_START;
                end

                ST_G_DIV_START:
                begin
                    // Rounded gain * m / mg as (2*gain*m + mg) / (2*mg)
                    req_reg.start     <= 1'b1;
                    req_reg.sqrt_mode <= 1'b0;
                    req_reg.steps     <= rpv_pkg::STEP_W'(21);
                    req_reg.rem_init  <= rpv_pkg::REM_W'(gdiv_num[63:21]);
                    req_reg.dsh_init  <= {gdiv_num[20:0], 43'b0};
                    req_reg.divisor   <= {31'b0, mg_reg, 1'b0};
                    state_reg         <= ST_G_DIV;
                end

                ST_G_DIV:
                begin
                    if (iter_rsp.done)
                    begin
                        goal_reg[axis_reg] <= comp_sat;
                        if (axis_reg == 2'd2)
                        begin
                            state_reg <= ST_G_OUT;
                        end
                        else
                        begin
                            axis_reg  <= axis_reg + 1'b1;
                            state_reg <= ST_G_MUL;
                        end
                    end
                end

                ST_G_OUT:
                begin
                    if (!out_valid_reg || goal.ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_applied_reg <= applied_reg;
                        out_kept_reg    <= kept_out;
                        if (applied_reg)
                        begin
                            out_x_reg <= goal_reg[0];
                            out_y_reg <= goal_reg[1];
                            out_z_reg <= goal_reg[2];
                        end
                        else
                        begin
                            out_x_reg <= '0;
                            out_y_reg <= '0;
                            out_z_reg <= cfg.forward_z;
                        end
                        for (int i = 0; i < 3; i++)
                        begin
                            sum_reg[i] <= '0;
                        end
                        count_reg <= '0;
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/point_cloud_repulsion_vector_core.sv =====
`timescale 1ns / 1ps

// Point-cloud repulsion vector. Each point transfer carries one 3D point in
// 2^-16 m; the cloud ends with the point flagged last, and only then is one goal
// transferred out. A front stage forms the offset from the robot position and
// puts the point in a two-entry queue, so the input can run ahead of the back
// end until the queue is full. The back end uses one 32x32 multiplier and one
// bit-serial divide/square-root unit that yields one result bit per cycle while
// busy, and that unit sets the pace: an invalid point is dropped in the idle
// state, a point outside the distance window ends at the window check, and a
// kept point runs the 29-step root, the 41-step 2^40/s weight and, for each
// nonzero axis, a 31-step division. The goal at the end of a cloud takes
// normalization plus squaring, root and division work. Configuration must be
// written by the user only while the block is idle; the block does not enforce it.
module point_cloud_repulsion_vector_core #(
    parameter int ACCUM_BITS = rpv_pkg::ACCUM_BITS_DEF,
    parameter int COUNT_BITS = rpv_pkg::COUNT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    rpv_point_if.sink                         point,
    rpv_goal_if.source                        goal,
    input  logic                              cfg_we,
    input  logic [rpv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rpv_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    logic signed [rpv_pkg::COORD_W-1:0] robot_x_reg;
    logic signed [rpv_pkg::COORD_W-1:0] robot_y_reg;
    logic signed [rpv_pkg::COORD_W-1:0] robot_z_reg;
    rpv_pkg::back_cfg_t                 cfg_reg;

    logic                  q_full;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_not_empty;
    rpv_pkg::point_entry_t q_push_data;
    rpv_pkg::point_entry_t q_pop_data;
    rpv_pkg::iter_req_t    iter_req;
    rpv_pkg::iter_rsp_t    iter_rsp;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            robot_x_reg        <= rpv_pkg::RST_ROBOT_X;
            robot_y_reg        <= rpv_pkg::RST_ROBOT_Y;
            robot_z_reg        <= rpv_pkg::RST_ROBOT_Z;
            cfg_reg.near_sq    <= rpv_pkg::RST_NEAR;
            cfg_reg.far_sq     <= rpv_pkg::RST_FAR;
            cfg_reg.min_points <= rpv_pkg::RST_MIN_PTS;
            cfg_reg.gain       <= rpv_pkg::RST_GAIN;
            cfg_reg.forward_z  <= rpv_pkg::RST_FORWARD_Z;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rpv_pkg::CFG_ROBOT_X:   robot_x_reg <= cfg_wdata[rpv_pkg::COORD_W-1:0];
                rpv_pkg::CFG_ROBOT_Y:   robot_y_reg <= cfg_wdata[rpv_pkg::COORD_W-1:0];
                rpv_pkg::CFG_ROBOT_Z:   robot_z_reg <= cfg_wdata[rpv_pkg::COORD_W-1:0];
                rpv_pkg::CFG_NEAR:      cfg_reg.near_sq <= cfg_wdata[rpv_pkg::LIMIT_W-1:0];
                rpv_pkg::CFG_FAR:       cfg_reg.far_sq <= cfg_wdata[rpv_pkg::LIMIT_W-1:0];
                rpv_pkg::CFG_MIN_PTS:   cfg_reg.min_points <= cfg_wdata[rpv_pkg::MINPTS_W-1:0];
                rpv_pkg::CFG_GAIN:      cfg_reg.gain <= cfg_wdata[rpv_pkg::GAIN_W-1:0];
                rpv_pkg::CFG_FORWARD_Z: cfg_reg.forward_z <= cfg_wdata[rpv_pkg::COORD_W-1:0];
                default:                robot_x_reg <= robot_x_reg;
            endcase
        end
    end

    // Front: offset and classification
    rpv_front u_front (
        .point   (point),
        .robot_x (robot_x_reg),
        .robot_y (robot_y_reg),
        .robot_z (robot_z_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_push_data)
    );

    // Queue between front and back
    rpv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_pop_data)
    );

    // Shared divide / square-root unit
    rpv_iter u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (iter_req),
        .rsp   (iter_rsp)
    );

    // Back: accumulation and goal
    rpv_back #(
        .ACCUM_BITS (ACCUM_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_pop_data),
        .q_pop       (q_pop),
        .cfg         (cfg_reg),
        .iter_req    (iter_req),
        .iter_rsp    (iter_rsp),
        .goal        (goal)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import rpv_pkg::*;

    // One point as it goes to the block
    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      invalid;
        logic                      last;
    } point_t;

    // One goal as it comes back
    typedef struct {
        logic signed [COORD_W-1:0] gx;
        logic signed [COORD_W-1:0] gy;
        logic signed [COORD_W-1:0] gz;
        logic [KEPT_OUT_W-1:0]     kept;
        logic                      applied;
    } goal_t;

    typedef enum int {OFS_WINDOW, OFS_WIDE, OFS_TINY} offset_kind_t;

    localparam int  ACC_W       = ACCUM_BITS_DEF;
    localparam int  CNT_W       = COUNT_BITS_DEF;
    localparam int  WATCH_LIMIT = 20000;
    localparam int  DRAIN_WAIT  = 400;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    rpv_point_if point_ch ();
    rpv_goal_if  goal_ch ();

    point_cloud_repulsion_vector_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .point     (point_ch),
        .goal      (goal_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the settings
    logic signed [COORD_W-1:0] robot [3];
    logic [LIMIT_W-1:0]        near_sq;
    logic [LIMIT_W-1:0]        far_sq;
    logic [MINPTS_W-1:0]       min_pts;
    logic [GAIN_W-1:0]         gain;
    logic signed [COORD_W-1:0] forward_z;

    // Shadow copy of the accumulators
    longint          push_sum [3];
    longint unsigned kept_count;

    point_t pending_points[$];
    goal_t  expected_goals[$];

    int   mismatches;
    int   points_sent;
    int   goals_checked;
    int   repulsed_goals;
    int   idle_cycles;
    int   cycle_count;
    logic calm;

    // Clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_wdata          = '0;
        point_ch.valid     = 1'b0;
        point_ch.point_x   = '0;
        point_ch.point_y   = '0;
        point_ch.point_z   = '0;
        point_ch.point_invalid = 1'b0;
        point_ch.last_point    = 1'b0;
        goal_ch.ready      = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Bit-by-bit integer square root
    function automatic longint unsigned root64(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    // Fold one valid point into the repulsion sums.
    function automatic void absorb_point(input point_t p);
        longint          rel [3];
        longint unsigned s;
        longint unsigned d;
        longint unsigned w;
        longint unsigned m;
        longint unsigned u;
        logic [127:0]    prod;
        longint          term;
        longint          top;
        longint          bottom;
        rel[0] = longint'(p.x) - longint'(robot[0]);
        rel[1] = longint'(p.y) - longint'(robot[1]);
        rel[2] = longint'(p.z) - longint'(robot[2]);
        s = 0;
        for (int i = 0; i < 3; i++)
            s += longint'(rel[i] * rel[i]);
        if (s < (longint'(near_sq) << FRAC_BITS) || s > (longint'(far_sq) << FRAC_BITS))
            return;
        if (kept_count < (64'd1 << CNT_W) - 1)
            kept_count++;
        if (s == 0)
            return;
        d = root64(s << 16);
        w = (64'd1 << 40) / s;
        top = (64'sd1 <<< (ACC_W - 1)) - 1;
        bottom = -top - 1;
        for (int i = 0; i < 3; i++)
        begin
            m = magnitude(rel[i]);
            if (m != 0)
            begin
                u = (m << 38) / d;
                prod = (128'(u) * 128'(w)) >> 30;
                term = (prod > 128'(64'h7FFF_FFFF_FFFF_FFFF)) ?
                       64'sh7FFF_FFFF_FFFF_FFFF : longint'(prod[63:0]);
                // The push points away from the obstacle.
                if (rel[i] < 0)
                    push_sum[i] = (push_sum[i] > top - term) ? top : push_sum[i] + term;
                else
                    push_sum[i] = (push_sum[i] < bottom + term) ? bottom : push_sum[i] - term;
            end
        end
    endfunction

    // Goal at the end of a cloud; clears the accumulated state.
    function automatic goal_t cloud_goal();
        goal_t           g;
        longint          comp [3];
        longint unsigned m [3];
        longint unsigned big;
        longint unsigned q;
        longint unsigned mg;
        longint unsigned c;
        logic            applied;
        comp[0] = 0;
        comp[1] = 0;
        comp[2] = longint'(forward_z);
        applied = (kept_count > longint'(min_pts)) &&
                  (push_sum[0] != 0 || push_sum[1] != 0 || push_sum[2] != 0);
        if (applied)
        begin
            big = 0;
            for (int i = 0; i < 3; i++)
            begin
                m[i] = magnitude(push_sum[i]);
                if (m[i] > big)
                    big = m[i];
            end
            // Normalize so the largest axis lies in [2^29, 2^30).
            while (big >= (64'd1 << 30))
            begin
                for (int i = 0; i < 3; i++)
                    m[i] >>= 1;
                big >>= 1;
            end
            while (big < (64'd1 << 29))
            begin
                for (int i = 0; i < 3; i++)
                    m[i] <<= 1;
                big <<= 1;
            end
            q = 0;
            for (int i = 0; i < 3; i++)
                q += m[i] * m[i];
            mg = root64(q);
            for (int i = 0; i < 3; i++)
            begin
                c = (2 * longint'(gain) * m[i] + mg) / (2 * mg);
                comp[i] += (push_sum[i] < 0) ? -longint'(c) : longint'(c);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            if (comp[i] > 524287)
                comp[i] = 524287;
            if (comp[i] < -524288)
                comp[i] = -524288;
        end
        g.gx = comp[0][COORD_W-1:0];
        g.gy = comp[1][COORD_W-1:0];
        g.gz = comp[2][COORD_W-1:0];
        g.kept = (kept_count > 64'hFF_FFFF) ? 24'hFF_FFFF : kept_count[KEPT_OUT_W-1:0];
        g.applied = applied;
        for (int i = 0; i < 3; i++)
            push_sum[i] = 0;
        kept_count = 0;
        return g;
    endfunction

    // Calm window: no idling on either side.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        calm <= (cycle_count % 60000) >= 20000 && (cycle_count % 60000) < 32000;
    end

    initial
    begin
        cycle_count = 0;
        calm = 1'b0;
        for (int i = 0; i < 3; i++)
            push_sum[i] = 0;
        kept_count = 0;
        robot[0] = RST_ROBOT_X;
        robot[1] = RST_ROBOT_Y;
        robot[2] = RST_ROBOT_Z;
        near_sq = RST_NEAR;
        far_sq = RST_FAR;
        min_pts = RST_MIN_PTS;
        gain = RST_GAIN;
        forward_z = RST_FORWARD_Z;
    end

    // Point driver: one transfer per accepted item, prediction at acceptance.
    always @(posedge clk)
    begin
        point_t p;
        if (rst_n)
        begin
            if (point_ch.valid && point_ch.ready)
            begin
                p.x = point_ch.point_x;
                p.y = point_ch.point_y;
                p.z = point_ch.point_z;
                p.invalid = point_ch.point_invalid;
                p.last = point_ch.last_point;
                points_sent++;
                if (!p.invalid)
                    absorb_point(p);
                if (p.last)
                    expected_goals.insert(expected_goals.size(), cloud_goal());
            end
            if (!point_ch.valid || point_ch.ready)
            begin
                if (pending_points.size() > 0 && (calm || $urandom_range(99) >= 25))
                begin
                    p = pending_points.pop_front();
                    point_ch.valid <= 1'b1;
                    point_ch.point_x <= p.x;
                    point_ch.point_y <= p.y;
                    point_ch.point_z <= p.z;
                    point_ch.point_invalid <= p.invalid;
                    point_ch.last_point <= p.last;
                end
                else
                    point_ch.valid <= 1'b0;
            end
        end
    end

    // Goal monitor: random back-pressure and field-by-field compare.
    always @(posedge clk)
    begin
        goal_t want;
        logic  bad;
        if (rst_n)
        begin
            goal_ch.ready <= calm || ($urandom_range(99) >= 25);
            if (goal_ch.valid && goal_ch.ready)
            begin
                if (expected_goals.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("goal transfer with none expected: %0d %0d %0d kept %0d",
                                 goal_ch.goal_x, goal_ch.goal_y, goal_ch.goal_z,
                                 goal_ch.kept_points);
                end
                else
                begin
                    want = expected_goals.pop_front();
                    goals_checked++;
                    if (want.applied)
                        repulsed_goals++;
                    bad = goal_ch.goal_x !== want.gx || goal_ch.goal_y !== want.gy ||
                          goal_ch.goal_z !== want.gz || goal_ch.kept_points !== want.kept ||
                          goal_ch.repulsion_applied !== want.applied;
                    if (bad)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $write("goal %0d: expected (%0d %0d %0d) kept %0d rep %0b, ",
                                   goals_checked, want.gx, want.gy, want.gz, want.kept,
                                   want.applied);
                            $display("got (%0d %0d %0d) kept %0d rep %0b",
                                     goal_ch.goal_x, goal_ch.goal_y, goal_ch.goal_z,
                                     goal_ch.kept_points, goal_ch.repulsion_applied);
                        end
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((point_ch.valid && point_ch.ready) || (goal_ch.valid && goal_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", WATCH_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            CFG_ROBOT_X:   robot[0] = data[COORD_W-1:0];
            CFG_ROBOT_Y:   robot[1] = data[COORD_W-1:0];
            CFG_ROBOT_Z:   robot[2] = data[COORD_W-1:0];
            CFG_NEAR:      near_sq = data[LIMIT_W-1:0];
            CFG_FAR:       far_sq = data[LIMIT_W-1:0];
            CFG_MIN_PTS:   min_pts = data[MINPTS_W-1:0];
            CFG_GAIN:      gain = data[GAIN_W-1:0];
            CFG_FORWARD_Z: forward_z = data[COORD_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic cfg_all(input longint rx, input longint ry, input longint rz,
                           input longint nr, input longint fr, input longint mp,
                           input longint gn, input longint fz);
        logic [CFG_DATA_W-1:0] junk;
        junk = $urandom;
        // Upper bits beyond each register's width carry random junk.
        cfg_write(CFG_ROBOT_X, {junk[3:0], rx[COORD_W-1:0]});
        cfg_write(CFG_ROBOT_Y, {junk[7:4], ry[COORD_W-1:0]});
        cfg_write(CFG_ROBOT_Z, {junk[11:8], rz[COORD_W-1:0]});
        cfg_write(CFG_NEAR, {junk[13:12], nr[LIMIT_W-1:0]});
        cfg_write(CFG_FAR, {junk[15:14], fr[LIMIT_W-1:0]});
        cfg_write(CFG_MIN_PTS, mp[MINPTS_W-1:0]);
        cfg_write(CFG_GAIN, {junk[20:16], gn[GAIN_W-1:0]});
        cfg_write(CFG_FORWARD_Z, {junk[23:20], fz[COORD_W-1:0]});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_points.size() > 0 || point_ch.valid || expected_goals.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic void add_point(input longint x, input longint y, input longint z,
                                      input logic inv, input logic lst);
        point_t p;
        p.x = x[COORD_W-1:0];
        p.y = y[COORD_W-1:0];
        p.z = z[COORD_W-1:0];
        p.invalid = inv;
        p.last = lst;
        pending_points.insert(pending_points.size(), p);
    endfunction

    function automatic longint offset(input offset_kind_t kind);
        longint span;
        case (kind)
            OFS_WINDOW:
            begin
                span = longint'(root64(longint'(far_sq) << FRAC_BITS));
                span = span + span / 4 + 2;
                if (span > 600000)
                    span = 600000;
            end
            OFS_WIDE: return longint'($urandom_range(0, 1048575)) - 524288;
            default:  span = 2;
        endcase
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    // A cloud of random points around the robot, on a scale set by the window.
    function automatic void add_cloud(input int len);
        offset_kind_t kind;
        int           pick;
        for (int k = 0; k < len; k++)
        begin
            pick = $urandom_range(99);
            kind = pick < 75 ? OFS_WINDOW : (pick < 88 ? OFS_WIDE : OFS_TINY);
            add_point(robot[0] + offset(kind), robot[1] + offset(kind), robot[2] + offset(kind),
                      $urandom_range(99) < 8, k == len - 1);
        end
    endfunction

    function automatic void add_random_clouds(input int items);
        int n;
        n = 0;
        while (n < items)
        begin
            add_cloud($urandom_range(1, 24));
            n = pending_points.size();
        end
    endfunction

    // Stimulus phases
    initial
    begin
        mismatches = 0;
        points_sent = 0;
        goals_checked = 0;
        repulsed_goals = 0;
        idle_cycles = 0;
        @(posedge rst_n);
        @(posedge clk);

        // Reset settings: field extremes, point at the robot, invalid points.
        add_point(524287, 524287, 524287, 1'b0, 1'b0);
        add_point(-524288, -524288, -524288, 1'b0, 1'b0);
        add_point(3932, 0, 0, 1'b0, 1'b0);
        add_point(3932 + 5000, 0, 0, 1'b0, 1'b0);
        add_point(3932, -6000, 0, 1'b0, 1'b0);
        add_point(3932, 0, 4000, 1'b1, 1'b0);
        add_point(3932 - 3278, 0, 0, 1'b0, 1'b0);
        add_point(3932 + 22702, 0, 0, 1'b0, 1'b1);
        add_point(0, 0, 0, 1'b1, 1'b1);
        add_point(3932 + 3300, 100, -200, 1'b0, 1'b1);
        for (int k = 0; k < 22; k++)
            add_point(3932 + 4000 + k, -3000, 2500, 1'b0, k == 21);
        wait_idle();
        add_random_clouds(150);
        wait_idle();

        // Open window, zero minimum, largest gain, most negative forward goal.
        cfg_all(0, 0, 0, 0, 4194303, 0, 524287, -524288);
        add_point(0, 0, 0, 1'b0, 1'b1);
        add_point(0, 0, 0, 1'b0, 1'b0);
        add_point(0, 0, -3, 1'b1, 1'b1);
        // Enough unit-distance points to saturate the accumulators.
        for (int k = 0; k < 140; k++)
            add_point(1, 0, 0, 1'b0, k == 139);
        add_random_clouds(120);
        wait_idle();

        // Robot at the corners, tiny window high up, minimum never reached.
        cfg_all(524287, -524288, 524287, 4194303, 4194303, 16777215, 524287, 524287);
        add_random_clouds(80);
        wait_idle();

        // Positive forward goal pushed over the top of the range.
        cfg_all(0, 0, 0, 0, 4194303, 0, 524287, 524287);
        for (int k = 0; k < 6; k++)
            add_point(100 * k, -50, -20000, 1'b0, k == 5);
        wait_idle();

        // Random settings
        for (int ph = 0; ph < 5; ph++)
        begin
            cfg_all(longint'($urandom_range(0, 1048575)) - 524288,
                    longint'($urandom_range(0, 1048575)) - 524288,
                    longint'($urandom_range(0, 1048575)) - 524288,
                    $urandom_range(0, 2000), $urandom_range(2000, 400000),
                    $urandom_range(0, 8), $urandom_range(0, 524287),
                    longint'($urandom_range(0, 1048575)) - 524288);
            add_random_clouds(110);
            wait_idle();
        end

        $display("Sent %0d points; checked %0d goals, %0d of them with repulsion.",
                 points_sent, goals_checked, repulsed_goals);
        $display("Settings covered reset values, window and gain extremes, random values.");
        if (mismatches == 0 && expected_goals.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
design/rpv_pkg.sv
design/rpv_stream_if.sv
design/rpv_front.sv
design/rpv_queue.sv
design/rpv_iter.sv
design/rpv_back.sv
design/point_cloud_repulsion_vector_core.sv
tb/testbench.sv
